FILE: rtl/uniform_grid_broadphase_macros.svh
// Assertion macros shared by the broad-phase RTL.
`ifndef UNIFORM_GRID_BROADPHASE_MACROS_SVH
`define UNIFORM_GRID_BROADPHASE_MACROS_SVH

`ifndef SYNTH
`define UGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define UGB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UGB_ASSERT_IMP(lbl, ante, cons, msg)
`define UGB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ugb_pkg.sv
`timescale 1ns / 1ps
package ugb_pkg;

  localparam int MAX_BODIES_DEF = 32;
  localparam int COORD_BITS_DEF = 32;

  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;
  localparam int SHIFT_W        = 5;
  localparam int CAND_W         = 32;
  localparam int STORED_W       = 6;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic run_query;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/ugb_ram.sv
`timescale 1ns / 1ps
module ugb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ugb_ctrl.sv
`timescale 1ns / 1ps
`include "uniform_grid_broadphase_macros.svh"
module ugb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output ugb_pkg::dp_cmd_t  ctl,
  input  ugb_pkg::dp_sts_t  sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.run_query ? S_ISSUE : S_DONE;
      end
      S_ISSUE: begin
        ctl.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `UGB_ASSERT_IMP(a_idle_pipe_empty, in_ready, !sts.pipe_busy, "item taken while pipe busy")
  `UGB_ASSERT_NXT(a_issue_fills_pipe, state_r == S_ISSUE, sts.pipe_busy, "issue left pipe empty")

endmodule

FILE: rtl/ugb_datapath.sv
`timescale 1ns / 1ps
`include "uniform_grid_broadphase_macros.svh"
module ugb_datapath #(
  parameter int MAX_BODIES = ugb_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = ugb_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ugb_pkg::SHIFT_W-1:0]         cfg_wdata,
  input  logic [ugb_pkg::CMD_W-1:0]           in_command,
  input  logic signed [COORD_BITS-1:0]        in_min_x,
  input  logic signed [COORD_BITS-1:0]        in_max_x,
  input  logic signed [COORD_BITS-1:0]        in_min_y,
  input  logic signed [COORD_BITS-1:0]        in_max_y,
  input  logic signed [COORD_BITS-1:0]        in_min_z,
  input  logic signed [COORD_BITS-1:0]        in_max_z,
  input  ugb_pkg::dp_cmd_t                    ctl,
  output ugb_pkg::dp_sts_t                    sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ugb_pkg::CAND_W-1:0]          out_candidates,
  output logic [ugb_pkg::STORED_W-1:0]        out_stored_bodies,
  output logic [ugb_pkg::STATUS_W-1:0]        out_status
);

  localparam int CB    = COORD_BITS;
  localparam int EW    = COORD_BITS + 1;
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam int AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int RW    = 6 * COORD_BITS;
  localparam int CANDW = ugb_pkg::CAND_W;
  localparam int STW   = ugb_pkg::STORED_W;
  localparam logic [CB-1:0] BIAS = {1'b1, {(CB-1){1'b0}}};

  logic [ugb_pkg::SHIFT_W-1:0]  shift_r;
  logic [ugb_pkg::CMD_W-1:0]    cmd_r;
  logic [2:0][CB-1:0]           q_lo_r, q_hi_r;
  logic [2:0][CB-1:0]           scene_lo_r, scene_hi_r;
  logic [CNT_W-1:0]             total_r;
  logic [CNT_W-1:0]             k_r;
  logic [ugb_pkg::STATUS_W-1:0] st_r;
  logic [CANDW-1:0]             cand_r;

  logic full, empty;
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [2:0][CB-1:0] r_lo, r_hi;

  // stage 1: clamp and offset
  logic               v1_r, q1_r;
  logic [AW-1:0]      idx1_r;
  logic [2:0][CB-1:0] op_lo, op_hi, cl, ch, dl, dh;
  logic [2:0]         ok_ax;

  // stage 2: cell range
  logic               v2_r, q2_r, ok2_r;
  logic [AW-1:0]      idx2_r;
  logic [2:0][CB-1:0] dl2_r, dh2_r;
  logic [2:0][CB-1:0] rem;
  logic [2:0][EW-1:0] f_c, e_c;

  // stage 3: overlap
  logic               v3_r, q3_r, ok3_r;
  logic [AW-1:0]      idx3_r;
  logic [2:0][EW-1:0] f3_r, e3_r;
  logic [2:0][EW-1:0] qf_r, qe_r;
  logic               qok_r;
  logic [2:0][EW-1:0] f_max, e_min;
  logic               hit;
  logic [CANDW-1:0]   hit_vec;

  logic                    out_valid_r;
  logic [CANDW-1:0]        out_cand_r;
  logic [STW-1:0]          out_stored_r;
  logic [ugb_pkg::STATUS_W-1:0] out_status_r;

  assign full  = total_r >= CNT_W'(MAX_BODIES);
  assign empty = total_r == '0;

  assign ram_we = ctl.exec && (cmd_r == ugb_pkg::CMD_ADD) && !full;
  assign waddr  = AW'(total_r);
  assign wdata  = {q_hi_r, q_lo_r};
  assign raddr  = AW'(k_r - CNT_W'(1));
  assign r_lo   = rdata[3*CB-1:0];
  assign r_hi   = rdata[RW-1:3*CB];

  ugb_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_BODIES)
  ) u_body_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= ugb_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r     <= in_command;
      q_lo_r[0] <= in_min_x ^ BIAS;
      q_hi_r[0] <= in_max_x ^ BIAS;
      q_lo_r[1] <= in_min_y ^ BIAS;
      q_hi_r[1] <= in_max_y ^ BIAS;
      q_lo_r[2] <= in_min_z ^ BIAS;
      q_hi_r[2] <= in_max_z ^ BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.exec) begin
      if (cmd_r == ugb_pkg::CMD_CLEAR) begin
        total_r <= '0;
      end else if (ram_we) begin
        total_r <= total_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      for (int a = 0; a < 3; a++) begin
        if (empty || q_lo_r[a] < scene_lo_r[a]) begin
          scene_lo_r[a] <= q_lo_r[a];
        end
        if (empty || q_hi_r[a] > scene_hi_r[a]) begin
          scene_hi_r[a] <= q_hi_r[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      unique case (cmd_r)
        ugb_pkg::CMD_ADD:   st_r <= full ? ugb_pkg::ST_FULL : ugb_pkg::ST_OK;
        ugb_pkg::CMD_QUERY: st_r <= empty ? ugb_pkg::ST_EMPTY : ugb_pkg::ST_OK;
        default:            st_r <= ugb_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      k_r <= '0;
    end else if (ctl.issue) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      op_lo[a] = q1_r ? q_lo_r[a] : r_lo[a];
      op_hi[a] = q1_r ? q_hi_r[a] : r_hi[a];
      cl[a] = (op_lo[a] < scene_lo_r[a]) ? scene_lo_r[a] :
              ((op_lo[a] > scene_hi_r[a]) ? scene_hi_r[a] : op_lo[a]);
      ch[a] = (op_hi[a] < scene_lo_r[a]) ? scene_lo_r[a] :
              ((op_hi[a] > scene_hi_r[a]) ? scene_hi_r[a] : op_hi[a]);
      ok_ax[a] = !((cl[a] < scene_lo_r[a]) || (ch[a] < scene_lo_r[a]));
      dl[a] = cl[a] - scene_lo_r[a];
      dh[a] = ch[a] - scene_lo_r[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem[a] = dh2_r[a] & ~({CB{1'b1}} << shift_r);
      f_c[a] = {1'b0, dl2_r[a] >> shift_r};
      e_c[a] = {1'b0, dh2_r[a] >> shift_r} + EW'(rem[a] != '0);
    end
  end

  always_comb begin
    hit = ok3_r && qok_r;
    for (int a = 0; a < 3; a++) begin
      f_max[a] = (f3_r[a] > qf_r[a]) ? f3_r[a] : qf_r[a];
      e_min[a] = (e3_r[a] < qe_r[a]) ? e3_r[a] : qe_r[a];
      if (f_max[a] >= e_min[a]) begin
        hit = 1'b0;
      end
    end
    hit_vec = '0;
    for (int b = 0; b < CANDW; b++) begin
      if (b < MAX_BODIES && idx3_r == AW'(b)) begin
        hit_vec[b] = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    q1_r   <= k_r == '0;
    idx1_r <= raddr;
    q2_r   <= q1_r;
    idx2_r <= idx1_r;
    ok2_r  <= &ok_ax;
    dl2_r  <= dl;
    dh2_r  <= dh;
    q3_r   <= q2_r;
    idx3_r <= idx2_r;
    ok3_r  <= ok2_r;
    f3_r   <= f_c;
    e3_r   <= e_c;
  end

  always_ff @(posedge clk) begin
    if (v3_r && q3_r) begin
      qf_r  <= f3_r;
      qe_r  <= e3_r;
      qok_r <= ok3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      cand_r <= '0;
    end else if (v3_r && !q3_r) begin
      cand_r <= cand_r | hit_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_cand_r   <= cand_r;
      out_stored_r <= STW'(total_r);
      out_status_r <= st_r;
    end
  end

  assign sts.run_query  = (cmd_r == ugb_pkg::CMD_QUERY) && !empty;
  assign sts.last_issue = k_r == total_r;
  assign sts.pipe_busy  = v1_r || v2_r || v3_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_candidates    = out_cand_r;
  assign out_stored_bodies = out_stored_r;
  assign out_status        = out_status_r;

  `UGB_ASSERT_IMP(a_total_bound, 1'b1, total_r <= CNT_W'(MAX_BODIES), "body count overflow")
  `UGB_ASSERT_IMP(a_no_overwrite, ctl.load_out, !out_valid_r || out_ready, "result overwritten")
  `UGB_ASSERT_IMP(a_pipe_order, v3_r, $past(v2_r), "stage 3 valid without stage 2")

endmodule

FILE: rtl/uniform_grid_broadphase.sv
`timescale 1ns / 1ps
// Broad-phase collision grid over axis-aligned boxes in signed Q16.16.
// Input channel (in_valid/in_ready): command 0 clears the store, 1 adds a
// body box, 2 queries a box. Each item yields exactly one result on the
// output channel (out_valid/out_ready): candidate bitmask, stored body
// count and status. cfg_we/cfg_wdata set the log2 cell size; write it only
// while the block is idle.
// Flow: clear, add, unused commands and queries on an empty store pass
// from execute straight to done, which loads the output register. A query
// with N >= 1 stored bodies issues first: the query box and then one stored
// body per cycle stream through a three-stage clamp, cell-range and overlap
// pipeline fed by the body RAM read port, which then drains before done.
// Throughput: one item at a time; in_ready is high only while idle, so the
// next item is taken only once the last has loaded its result into the
// output register.
// Reset: body count goes to 0 and the cell shift to 16; no clearing pass.
// Stall: a finished result sits in the output register while the next item
// is taken and worked on; that item then waits for the register to free.
module uniform_grid_broadphase #(
  parameter int MAX_BODIES = ugb_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = ugb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ugb_pkg::SHIFT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ugb_pkg::CMD_W-1:0]     in_command,
  input  logic signed [COORD_BITS-1:0]  in_min_x,
  input  logic signed [COORD_BITS-1:0]  in_max_x,
  input  logic signed [COORD_BITS-1:0]  in_min_y,
  input  logic signed [COORD_BITS-1:0]  in_max_y,
  input  logic signed [COORD_BITS-1:0]  in_min_z,
  input  logic signed [COORD_BITS-1:0]  in_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ugb_pkg::CAND_W-1:0]    out_candidates,
  output logic [ugb_pkg::STORED_W-1:0]  out_stored_bodies,
  output logic [ugb_pkg::STATUS_W-1:0]  out_status
);

  ugb_pkg::dp_cmd_t ctl;
  ugb_pkg::dp_sts_t sts;

  ugb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ctl     (ctl),
    .sts     (sts)
  );

  ugb_datapath #(
    .MAX_BODIES(MAX_BODIES),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_min_x         (in_min_x),
    .in_max_x         (in_max_x),
    .in_min_y         (in_min_y),
    .in_max_y         (in_max_y),
    .in_min_z         (in_min_z),
    .in_max_z         (in_max_z),
    .ctl              (ctl),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_candidates   (out_candidates),
    .out_stored_bodies(out_stored_bodies),
    .out_status       (out_status)
  );

endmodule
